/* src/sbct_pkg.sv */
// Shared types, codes and code-page tables for the codepage transcoder.
`timescale 1ns / 1ps
`default_nettype none

package sbct_pkg;

  typedef enum logic [1:0] {
    CMD_DECODE = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_UNMAPPED = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  localparam logic [1:0] BASE_ASCII = 2'd0;
  localparam logic [1:0] BASE_WIN   = 2'd1;
  localparam logic [1:0] BASE_MAC   = 2'd2;

  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] uni;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] uni;
  } rev_entry_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] uni;
  } dec_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } enc_t;

  // WinAnsi 0x80-0x9F; zero marks an unassigned code
  localparam logic [15:0] WIN_BLOCK [32] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  // MacRoman 0x80-0xFF
  localparam logic [15:0] MAC_HIGH [128] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  // Byte to character through ASCII and the base code page; a miss leaves uni zero
  function automatic dec_t base_decode(input logic [7:0] code, input logic [1:0] base);
    dec_t r;
    r.hit = 1'b0;
    r.uni = '0;
    if (code >= 8'h20 && code <= 8'h7E) begin
      r.hit = 1'b1;
      r.uni = {8'h00, code};
    end else if (base == BASE_WIN) begin
      if (code[7:5] == 3'b100) begin
        r.uni = WIN_BLOCK[code[4:0]];
        r.hit = (r.uni != 16'h0000);
      end else if (code[7]) begin
        r.hit = 1'b1;
        r.uni = {8'h00, code};
      end
    end else if (base == BASE_MAC && code[7]) begin
      r.hit = 1'b1;
      r.uni = MAC_HIGH[code[6:0]];
    end
    return r;
  endfunction

  // Character to byte; table values are unique, so matches are OR-merged
  function automatic enc_t base_encode(input logic [15:0] v, input logic [1:0] base);
    enc_t r;
    r.hit  = 1'b0;
    r.code = '0;
    if (v >= 16'h0020 && v <= 16'h007E) begin
      r.hit  = 1'b1;
      r.code = v[7:0];
    end else if (base == BASE_WIN) begin
      for (int i = 0; i < 32; i++) begin
        if (WIN_BLOCK[i] != 16'h0000 && WIN_BLOCK[i] == v) begin
          r.hit  = 1'b1;
          r.code = r.code | (8'h80 | 8'(i));
        end
      end
      if (!r.hit && v >= 16'h00A0 && v <= 16'h00FF) begin
        r.hit  = 1'b1;
        r.code = v[7:0];
      end
    end else if (base == BASE_MAC) begin
      for (int i = 0; i < 128; i++) begin
        if (MAC_HIGH[i] == v) begin
          r.hit  = 1'b1;
          r.code = r.code | (8'h80 | 8'(i));
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/sbct_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sbct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/sbct_ctrl.sv */
// Command sequencer: overlay memories, reverse-store search and result build.
`timescale 1ns / 1ps
`default_nettype none

module sbct_ctrl import sbct_pkg::*; #(
  parameter int REVERSE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  base,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire cmd_t        in_cmd,
  input  wire logic [7:0]  in_code,
  input  wire logic [15:0] in_uni,
  output logic             res_valid,
  input  wire logic        res_ready,
  output result_t          res
);

  localparam int AW = (REVERSE_DEPTH > 1) ? $clog2(REVERSE_DEPTH) : 1;
  localparam int CW = $clog2(REVERSE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(REVERSE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FWD_WAIT,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t      state;
  cmd_t        cmd;
  logic [7:0]  code;
  logic [15:0] uni;
  logic [255:0] fwd_valid;
  logic [CW-1:0] rev_count;
  logic [CW-1:0] idx;

  logic [CW-1:0] idx_next;
  dec_t        dec_base;
  enc_t        enc_base;
  logic        fwd_we;
  logic [15:0] fwd_rdata;
  logic        rev_we;
  logic [AW-1:0] rev_raddr;
  rev_entry_t  rev_wdata;
  rev_entry_t  rev_rdata;
  logic        rev_match;
  logic        rev_more;
  logic        full;

  assign idx_next  = idx + 1'b1;
  assign dec_base  = base_decode(code, base);
  assign enc_base  = base_encode(uni, base);
  assign rev_match = (rev_rdata.uni == uni);
  assign rev_more  = (idx_next < rev_count);
  assign full      = (rev_count == FULL_COUNT);
  assign rev_raddr = (state == S_SEARCH) ? idx_next[AW-1:0] : '0;
  assign rev_wdata = '{code: code, uni: uni};

  assign fwd_we = (state == S_EXEC) && (cmd == CMD_LOAD) && (uni != 16'h0000);
  assign rev_we = (fwd_we && rev_count == '0) ||
                  ((state == S_SEARCH) && (cmd == CMD_LOAD) && !rev_match && !rev_more && !full);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  sbct_ram #(
    .WIDTH (16),
    .DEPTH (256)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (code),
    .wdata (uni),
    .raddr (code),
    .rdata (fwd_rdata)
  );

  sbct_ram #(
    .WIDTH ($bits(rev_entry_t)),
    .DEPTH (REVERSE_DEPTH)
  ) u_rev_ram (
    .clk   (clk),
    .we    (rev_we),
    .waddr (rev_count[AW-1:0]),
    .wdata (rev_wdata),
    .raddr (rev_raddr),
    .rdata (rev_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fwd_valid <= '0;
      rev_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_cmd;
            code  <= in_code;
            uni   <= in_uni;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx <= '0;
          case (cmd)
            CMD_DECODE: begin
              res   <= '{code: 8'h00, uni: 16'h0000, status: STAT_OK};
              state <= S_FWD_WAIT;
            end
            CMD_ENCODE: begin
              if (uni == 16'h0000) begin
                res   <= '{code: 8'h00, uni: 16'h0000, status: STAT_UNMAPPED};
                state <= S_DONE;
              end else if (rev_count == '0) begin
                res   <= '{code: enc_base.code, uni: 16'h0000,
                           status: enc_base.hit ? STAT_OK : STAT_UNMAPPED};
                state <= S_DONE;
              end else begin
                res   <= '{code: 8'h00, uni: 16'h0000, status: STAT_OK};
                state <= S_SEARCH;
              end
            end
            CMD_LOAD: begin
              if (uni == 16'h0000) begin
                res   <= '{code: 8'h00, uni: 16'h0000, status: STAT_UNMAPPED};
                state <= S_DONE;
              end else begin
                res             <= '{code: 8'h00, uni: 16'h0000, status: STAT_OK};
                fwd_valid[code] <= 1'b1;
                if (rev_count == '0) begin
                  rev_count <= rev_count + 1'b1;
                  state     <= S_DONE;
                end else begin
                  state <= S_SEARCH;
                end
              end
            end
            default: begin
              res       <= '{code: 8'h00, uni: 16'h0000, status: STAT_OK};
              fwd_valid <= '0;
              rev_count <= '0;
              state     <= S_DONE;
            end
          endcase
        end
        S_FWD_WAIT: begin
          if (fwd_valid[code]) begin
            res.uni <= fwd_rdata;
          end else begin
            res.uni    <= dec_base.uni;
            res.status <= dec_base.hit ? STAT_OK : STAT_UNMAPPED;
          end
          state <= S_DONE;
        end
        S_SEARCH: begin
          if (rev_match) begin
            if (cmd == CMD_ENCODE) begin
              res.code <= rev_rdata.code;
            end
            state <= S_DONE;
          end else if (rev_more) begin
            idx <= idx_next;
          end else begin
            // no overlay hit: fall back to the base page, or append unless the store is full
            if (cmd == CMD_ENCODE) begin
              res.code   <= enc_base.code;
              res.status <= enc_base.hit ? STAT_OK : STAT_UNMAPPED;
            end else if (full) begin
              res.status <= STAT_FULL;
            end else begin
              rev_count <= rev_count + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rev_count <= FULL_COUNT)
    else $error("reverse count exceeds store depth");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    rev_we |-> !full)
    else $error("reverse store written while full");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && cmd == CMD_CLEAR) |=> (rev_count == '0 && fwd_valid == '0))
    else $error("clear left overlay entries");

  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (idx < rev_count))
    else $error("search index beyond filled entries");

  a_full_only_on_load: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STAT_FULL) |-> (cmd == CMD_LOAD))
    else $error("store-full status on a non-load item");
`endif

endmodule

`default_nettype wire

/* src/single_byte_codepage_transcoder.sv */
// Top level of the single-byte code page transcoder: config register and output stage.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the command in s_tuser and
//   byte code plus character in s_tdata. Each item yields exactly one result
//   item on m_tvalid/m_tready: encoded byte and decoded character in m_tdata,
//   status in m_tuser. cfg_we/cfg_wdata write the base encoding selector
//   (0 ASCII, 1 WinAnsi, 2 MacRoman, 3 acts as ASCII); the user must write it
//   only while the block is idle, which the block does not enforce. Items are
//   processed one at a time. Clear, a load or encode of character zero, and
//   a load or encode with an empty reverse store go from the execute state
//   straight to done; decode adds a forward-wait state (one forward overlay
//   read). Encode and load otherwise scan the reverse overlay one entry per
//   cycle until the first match or the last filled entry. The next item is
//   accepted once the result moves to the output register. Reset clears the
//   base selector, the forward valid bits and the reverse fill count; no
//   clearing pass is needed. When the receiver stalls, the result holds in
//   the output register while the next item is accepted and worked on; that
//   item then waits in the sequencer until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module single_byte_codepage_transcoder import sbct_pkg::*; #(
  parameter int REVERSE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] byte_code, [23:8] unicode_value
  input  wire logic [1:0]  s_tuser,   // [1:0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] out_code, [23:8] out_unicode
  output logic [1:0]       m_tuser    // [1:0] status
);

  logic [1:0] base_encoding;
  logic       res_valid;
  logic       res_ready;
  result_t    res;

  assign res_ready = !m_tvalid || m_tready;

  sbct_ctrl #(
    .REVERSE_DEPTH (REVERSE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .base      (base_encoding),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (cmd_t'(s_tuser)),
    .in_code   (s_tdata[7:0]),
    .in_uni    (s_tdata[23:8]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_encoding <= BASE_ASCII;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_encoding <= cfg_wdata;
      end
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {res.uni, res.code};
        m_tuser  <= res.status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
